/* src/bilinear_texel_16bit_assert.svh */
// Assertion macros shared by the checker files.
// Every macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef BILINEAR_TEXEL_16BIT_ASSERT_SVH
`define BILINEAR_TEXEL_16BIT_ASSERT_SVH

// The consequent must hold whenever the antecedent holds.
`define BTEX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("btex assertion failed");

// The condition must never hold.
`define BTEX_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("btex assertion failed");

`endif

/* src/btex_pkg.sv */
package btex_pkg;

  localparam int unsigned WEIGHT_FRAC_BITS = 16;

  localparam int unsigned TEXEL_W  = 16;
  localparam int unsigned WEIGHT_W = 17;
  // a saturated weight holds 0 .. 1.0
  localparam int unsigned SAT_W    = WEIGHT_FRAC_BITS + 1;
  localparam int unsigned WEXT_W   = (WEIGHT_W > SAT_W) ? WEIGHT_W : SAT_W;

  localparam int unsigned NUM_CH   = 4;
  localparam int unsigned NUM_CORNER = 4;
  localparam int unsigned CH_W     = 5;
  // first pass result, value scaled by 2^F, never negative
  localparam int unsigned U_W      = CH_W + WEIGHT_FRAC_BITS;
  localparam int unsigned D_W      = U_W + 1;
  // second pass result, value scaled by 2^(2F)
  localparam int unsigned R_W      = CH_W + 2 * WEIGHT_FRAC_BITS;
  localparam int unsigned Q_W      = R_W + 1 - 2 * WEIGHT_FRAC_BITS;

  localparam logic [SAT_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};

  // channel lanes
  localparam int unsigned CH_B = 0;
  localparam int unsigned CH_G = 1;
  localparam int unsigned CH_R = 2;
  localparam int unsigned CH_A = 3;

  // corner order: 00, 10, 01, 11
  localparam int unsigned C00 = 0;
  localparam int unsigned C10 = 1;
  localparam int unsigned C01 = 2;
  localparam int unsigned C11 = 3;

  localparam logic [Q_W-1:0] MAX_1555_A = Q_W'(1);
  localparam logic [Q_W-1:0] MAX_1555_C = Q_W'(31);
  localparam logic [Q_W-1:0] MAX_4444   = Q_W'(15);

  typedef enum logic {
    FMT_1555 = 1'b0,
    FMT_4444 = 1'b1
  } texel_fmt_e;

  typedef logic [CH_W-1:0]   chan_t;
  typedef chan_t [NUM_CH-1:0] chan_vec_t;
  typedef logic [U_W-1:0]    upass_t;
  typedef logic [R_W-1:0]    rpass_t;

endpackage

/* src/bilinear_texel_16bit.sv */
// Channel   | Direction | Ports                                              | Handshake
// ----------+-----------+----------------------------------------------------+-------------------
// command   | in        | corner_00_i, corner_10_i, corner_01_i,             | start_i & !busy_o
//           |           | corner_11_i, weight_s_i, weight_t_i                |
// result    | out       | texel_result_o                                     | done_o, one cycle
// config    | in        | cfg_wdata_i (texel_format)                         | cfg_we_i
//
// One word enters per clock; busy_o is never raised since the receiver cannot stall.
// The pipe registers in turn: unpack/saturate, first lerp along s, second lerp along t,
// then round, clamp and repack into the output register.
// The two multiplier stages (6x18 per corner pair, 22x18 per channel) set the clock.
// rst_ni clears the valid bits, the done strobe and texel_format (ARGB1555).
// The format is sampled with each word and travels with it down the pipe.
module bilinear_texel_16bit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [btex_pkg::TEXEL_W-1:0]  corner_00_i,
  input  logic [btex_pkg::TEXEL_W-1:0]  corner_10_i,
  input  logic [btex_pkg::TEXEL_W-1:0]  corner_01_i,
  input  logic [btex_pkg::TEXEL_W-1:0]  corner_11_i,
  input  logic [btex_pkg::WEIGHT_W-1:0] weight_s_i,
  input  logic [btex_pkg::WEIGHT_W-1:0] weight_t_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  output logic                          done_o,
  output logic [btex_pkg::TEXEL_W-1:0]  texel_result_o
);

  localparam int unsigned F   = btex_pkg::WEIGHT_FRAC_BITS;
  localparam int unsigned CW  = btex_pkg::CH_W;
  localparam int unsigned SW  = btex_pkg::SAT_W;
  localparam int unsigned UW  = btex_pkg::U_W;
  localparam int unsigned DW  = btex_pkg::D_W;
  localparam int unsigned RW  = btex_pkg::R_W;
  localparam int unsigned QW  = btex_pkg::Q_W;
  localparam int unsigned XW  = btex_pkg::WEXT_W;
  localparam int unsigned NCH = btex_pkg::NUM_CH;
  localparam int unsigned NCR = btex_pkg::NUM_CORNER;

  // format register
  btex_pkg::texel_fmt_e fmt_q, fmt_d;

  assign fmt_d = cfg_we_i ? btex_pkg::texel_fmt_e'(cfg_wdata_i) : fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= btex_pkg::FMT_1555;
    end else begin
      fmt_q <= fmt_d;
    end
  end

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------------
  // Stage A: saturate weights, unpack the four corners into channel lanes
  // ---------------------------------------------------------------------------
  logic                              a_vld_q;
  btex_pkg::texel_fmt_e              a_fmt_q;
  logic [SW-1:0]                     a_s_q, a_s_d, a_t_q, a_t_d;
  btex_pkg::chan_vec_t [NCR-1:0]     a_ch_q, a_ch_d;

  always_comb begin
    logic [btex_pkg::TEXEL_W-1:0] cr [NCR];
    logic [XW-1:0] ws, wt;
    cr[btex_pkg::C00] = corner_00_i;
    cr[btex_pkg::C10] = corner_10_i;
    cr[btex_pkg::C01] = corner_01_i;
    cr[btex_pkg::C11] = corner_11_i;
    ws = XW'(weight_s_i);
    wt = XW'(weight_t_i);
    a_s_d = (ws > XW'(btex_pkg::WEIGHT_ONE)) ? btex_pkg::WEIGHT_ONE : SW'(ws);
    a_t_d = (wt > XW'(btex_pkg::WEIGHT_ONE)) ? btex_pkg::WEIGHT_ONE : SW'(wt);
    for (int k = 0; k < NCR; k++) begin
      case (fmt_q)
        btex_pkg::FMT_1555: begin
          a_ch_d[k][btex_pkg::CH_A] = CW'(cr[k][15]);
          a_ch_d[k][btex_pkg::CH_R] = cr[k][14:10];
          a_ch_d[k][btex_pkg::CH_G] = cr[k][9:5];
          a_ch_d[k][btex_pkg::CH_B] = cr[k][4:0];
        end
        btex_pkg::FMT_4444: begin
          a_ch_d[k][btex_pkg::CH_A] = CW'(cr[k][15:12]);
          a_ch_d[k][btex_pkg::CH_R] = CW'(cr[k][11:8]);
          a_ch_d[k][btex_pkg::CH_G] = CW'(cr[k][7:4]);
          a_ch_d[k][btex_pkg::CH_B] = CW'(cr[k][3:0]);
        end
        default: begin
          a_ch_d[k] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_fmt_q <= fmt_q;
      a_s_q   <= a_s_d;
      a_t_q   <= a_t_d;
      a_ch_q  <= a_ch_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: u = c00*one + (c10-c00)*s, v = c01*one + (c11-c01)*s
  // Sums are taken modulo 2^UW; the true value always fits.
  // ---------------------------------------------------------------------------
  logic                        b_vld_q;
  btex_pkg::texel_fmt_e        b_fmt_q;
  logic [SW-1:0]               b_t_q;
  btex_pkg::upass_t [NCH-1:0]  b_u_q, b_u_d, b_v_q, b_v_d;

  always_comb begin
    logic signed [CW:0]      du, dv;
    logic signed [SW:0]      ss;
    logic signed [CW+SW+1:0] pu, pv;
    ss = $signed({1'b0, a_s_q});
    for (int c = 0; c < NCH; c++) begin
      du = $signed({1'b0, a_ch_q[btex_pkg::C10][c]}) - $signed({1'b0, a_ch_q[btex_pkg::C00][c]});
      dv = $signed({1'b0, a_ch_q[btex_pkg::C11][c]}) - $signed({1'b0, a_ch_q[btex_pkg::C01][c]});
      pu = du * ss;
      pv = dv * ss;
      b_u_d[c] = (UW'(a_ch_q[btex_pkg::C00][c]) << F) + UW'(pu);
      b_v_d[c] = (UW'(a_ch_q[btex_pkg::C01][c]) << F) + UW'(pv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      b_fmt_q <= a_fmt_q;
      b_t_q   <= a_t_q;
      b_u_q   <= b_u_d;
      b_v_q   <= b_v_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: r = u*one + (v-u)*t, modulo 2^RW (true value never negative)
  // ---------------------------------------------------------------------------
  logic                        c_vld_q;
  btex_pkg::texel_fmt_e        c_fmt_q;
  btex_pkg::rpass_t [NCH-1:0]  c_r_q, c_r_d;

  always_comb begin
    logic signed [DW-1:0]    d;
    logic signed [SW:0]      ts;
    logic signed [DW+SW:0]   p;
    ts = $signed({1'b0, b_t_q});
    for (int c = 0; c < NCH; c++) begin
      d = $signed({1'b0, b_v_q[c]}) - $signed({1'b0, b_u_q[c]});
      p = d * ts;
      c_r_d[c] = (RW'(b_u_q[c]) << F) + RW'(p);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      c_fmt_q <= b_fmt_q;
      c_r_q   <= c_r_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: add one half, floor, clamp to channel max, repack
  // ---------------------------------------------------------------------------
  logic                          done_q;
  logic [btex_pkg::TEXEL_W-1:0]  res_q, res_d;

  always_comb begin
    logic [RW:0]    sum;
    logic [QW-1:0]  q [NCH];
    logic [QW-1:0]  qmax;
    for (int c = 0; c < NCH; c++) begin
      sum = {1'b0, c_r_q[c]} + ((RW + 1)'(1) << (2 * F - 1));
      q[c] = sum[RW:2*F];
      case (c_fmt_q)
        btex_pkg::FMT_1555: qmax = (c == btex_pkg::CH_A) ? btex_pkg::MAX_1555_A
                                                         : btex_pkg::MAX_1555_C;
        btex_pkg::FMT_4444: qmax = btex_pkg::MAX_4444;
        default:            qmax = btex_pkg::MAX_4444;
      endcase
      if (q[c] > qmax) begin
        q[c] = qmax;
      end
    end
    case (c_fmt_q)
      btex_pkg::FMT_1555: res_d = {q[btex_pkg::CH_A][0], q[btex_pkg::CH_R][4:0],
                                   q[btex_pkg::CH_G][4:0], q[btex_pkg::CH_B][4:0]};
      btex_pkg::FMT_4444: res_d = {q[btex_pkg::CH_A][3:0], q[btex_pkg::CH_R][3:0],
                                   q[btex_pkg::CH_G][3:0], q[btex_pkg::CH_B][3:0]};
      default:            res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o         = done_q;
  assign texel_result_o = res_q;

endmodule

/* src/btex_checker.sv */
`include "bilinear_texel_16bit_assert.svh"

module btex_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [btex_pkg::TEXEL_W-1:0]  corner_00_i,
  input logic [btex_pkg::TEXEL_W-1:0]  corner_10_i,
  input logic [btex_pkg::TEXEL_W-1:0]  corner_01_i,
  input logic [btex_pkg::TEXEL_W-1:0]  corner_11_i,
  input logic [btex_pkg::WEIGHT_W-1:0] weight_s_i,
  input logic [btex_pkg::WEIGHT_W-1:0] weight_t_i,
  input logic                          cfg_we_i,
  input logic                          cfg_wdata_i,
  input logic                          done_o,
  input logic [btex_pkg::TEXEL_W-1:0]  texel_result_o
);

  // the receiver cannot stall, so the pipe never pushes back
  `BTEX_ASSERT_NEVER(busy_never_set, busy_o)

  // every accepted word comes back with done_o, nothing dropped
  `BTEX_ASSERT_IMP(done_follows_start, start_i && !busy_o, ##4 done_o)

  // nothing invented
  `BTEX_ASSERT_IMP(done_has_start, done_o, $past(start_i && !busy_o, 4))

  // zero weights pass corner 00 through unchanged in either format
  `BTEX_ASSERT_IMP(zero_weight_passthru,
    start_i && !busy_o && weight_s_i == '0 && weight_t_i == '0,
    ##4 (texel_result_o == $past(corner_00_i, 4)))

endmodule

bind bilinear_texel_16bit btex_checker u_btex_checker (.*);

/* verif/bilinear_texel_16bit_test.sv */
module bilinear_texel_16bit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import btex_pkg::*;

  // One row of the directed table. When has_known is set the expected word is
  // typed in (corner copies, extremes, round-half-up cases); otherwise the
  // texel filter predictor supplies it.
  typedef struct packed {
    texel_fmt_e          fmt;
    logic [TEXEL_W-1:0]  c00;
    logic [TEXEL_W-1:0]  c10;
    logic [TEXEL_W-1:0]  c01;
    logic [TEXEL_W-1:0]  c11;
    logic [WEIGHT_W-1:0] ws;
    logic [WEIGHT_W-1:0] wt;
    logic                has_known;
    logic [TEXEL_W-1:0]  known_texel;
  } texel_vector_t;

  localparam int unsigned NUM_VECTORS  = 23;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned PHASE_WORDS  = 215;
  localparam int unsigned PIPE_FLUSH   = 10;   // idle clocks after the final drain
  localparam int unsigned REPORT_LIMIT = 10;

  localparam texel_vector_t TEXEL_VECTORS [NUM_VECTORS] = '{
    // ARGB1555: all zero, all ones
    '{FMT_1555, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'd0, 17'd0, 1'b1, 16'h0000},
    '{FMT_1555, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'd65536, 17'd65536, 1'b1, 16'hFFFF},
    // weights at the corners select one texel unchanged
    '{FMT_1555, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 17'd0, 17'd0, 1'b1, 16'h1234},
    '{FMT_1555, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 17'd65536, 17'd0, 1'b1, 16'hABCD},
    '{FMT_1555, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 17'd0, 17'd65536, 1'b1, 16'h5A5A},
    '{FMT_1555, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 17'd65536, 17'd65536, 1'b1, 16'hA5A5},
    // weights above 1.0 saturate: max code and one step past one
    '{FMT_1555, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 17'h1FFFF, 17'h1FFFF, 1'b1, 16'hA5A5},
    '{FMT_1555, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 17'h10001, 17'd0, 1'b1, 16'hABCD},
    // alpha bit at exactly one half rounds up
    '{FMT_1555, 16'h0000, 16'h8000, 16'h0000, 16'h8000, 17'd32768, 17'd0, 1'b1, 16'h8000},
    // just below one half rounds down
    '{FMT_1555, 16'h0000, 16'h0001, 16'h0000, 16'h0001, 17'd32767, 17'd0, 1'b1, 16'h0000},
    '{FMT_1555, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 17'd32768, 17'd32768, 1'b0, 16'h0000},
    '{FMT_1555, 16'h8421, 16'h7BDE, 16'h03E0, 16'hFC1F, 17'd12345, 17'd54321, 1'b0, 16'h0000},
    '{FMT_1555, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 17'd1, 17'd65535, 1'b0, 16'h0000},
    // ARGB4444
    '{FMT_4444, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'd0, 17'd0, 1'b1, 16'h0000},
    '{FMT_4444, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF, 1'b1, 16'hFFFF},
    '{FMT_4444, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 17'd0, 17'd0, 1'b1, 16'h1234},
    '{FMT_4444, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 17'd65536, 17'd65536, 1'b1, 16'hA5A5},
    '{FMT_4444, 16'h1234, 16'hABCD, 16'h5A5A, 16'hA5A5, 17'd0, 17'h1FFFF, 1'b1, 16'h5A5A},
    // every nibble 0 -> 1 at one half
    '{FMT_4444, 16'h0000, 16'h1111, 16'h0000, 16'h1111, 17'd32768, 17'd0, 1'b1, 16'h1111},
    // alpha 0 -> 15 at one half gives 7.5, rounds to 8
    '{FMT_4444, 16'h0000, 16'hF000, 16'h0000, 16'hF000, 17'd32768, 17'd0, 1'b1, 16'h8000},
    '{FMT_4444, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 17'd32768, 17'd32768, 1'b1, 16'h8888},
    '{FMT_4444, 16'hF0F0, 16'h0F0F, 16'h3C3C, 16'hC3C3, 17'd20000, 17'd40000, 1'b0, 16'h0000},
    // back to 1555 so the register goes both ways
    '{FMT_1555, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 17'd32768, 17'd32768, 1'b0, 16'h0000}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [TEXEL_W-1:0]  corner_00_i = '0;
  logic [TEXEL_W-1:0]  corner_10_i = '0;
  logic [TEXEL_W-1:0]  corner_01_i = '0;
  logic [TEXEL_W-1:0]  corner_11_i = '0;
  logic [WEIGHT_W-1:0] weight_s_i = '0;
  logic [WEIGHT_W-1:0] weight_t_i = '0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b0;
  logic                done_o;
  logic [TEXEL_W-1:0]  texel_result_o;

  // filtered texels still owed by the block, oldest first
  logic [TEXEL_W-1:0]  texels_due [$];
  int unsigned         texel_faults = 0;
  // predictor's copy of texel_format
  texel_fmt_e          fmt_now = FMT_1555;

  always #5 clk_i = ~clk_i;

  bilinear_texel_16bit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .corner_00_i    (corner_00_i),
    .corner_10_i    (corner_10_i),
    .corner_01_i    (corner_01_i),
    .corner_11_i    (corner_11_i),
    .weight_s_i     (weight_s_i),
    .weight_t_i     (weight_t_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .texel_result_o (texel_result_o)
  );

  // One channel lane: lerp along s on both rows, then along t, all exact in
  // 2F fraction bits. Round half up, then clamp to the lane maximum.
  function automatic longint lerp_lane(longint c00, longint c10, longint c01, longint c11,
                                       longint s, longint t, longint lane_max);
    longint one;
    longint u;
    longint v;
    longint r;
    longint q;
    one = longint'(1) << WEIGHT_FRAC_BITS;
    u = c00 * one + (c10 - c00) * s;
    v = c01 * one + (c11 - c01) * s;
    r = u * one + (v - u) * t;
    if (r < 0) r = 0;
    q = (r + (longint'(1) << (2 * WEIGHT_FRAC_BITS - 1))) >>> (2 * WEIGHT_FRAC_BITS);
    return (q > lane_max) ? lane_max : q;
  endfunction

  // Filtered texel for one word, packed in the given format.
  function automatic logic [TEXEL_W-1:0] filter_texel(
    texel_fmt_e fmt,
    logic [TEXEL_W-1:0] c00, logic [TEXEL_W-1:0] c10,
    logic [TEXEL_W-1:0] c01, logic [TEXEL_W-1:0] c11,
    logic [WEIGHT_W-1:0] ws, logic [WEIGHT_W-1:0] wt);
    longint s;
    longint t;
    int     shift;
    longint lane_max;
    longint lane;
    longint packed_texel;
    s = (ws > WEIGHT_W'(WEIGHT_ONE)) ? longint'(WEIGHT_ONE) : longint'(ws);
    t = (wt > WEIGHT_W'(WEIGHT_ONE)) ? longint'(WEIGHT_ONE) : longint'(wt);
    packed_texel = 0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      // 1555: lanes 5 bits apart, alpha a single bit; 4444: nibbles
      if (fmt == FMT_1555) begin
        shift    = ch * 5;
        lane_max = (ch == CH_A) ? 1 : 31;
      end else begin
        shift    = ch * 4;
        lane_max = 15;
      end
      lane = lerp_lane((c00 >> shift) & lane_max, (c10 >> shift) & lane_max,
                       (c01 >> shift) & lane_max, (c11 >> shift) & lane_max,
                       s, t, lane_max);
      packed_texel = packed_texel | (lane << shift);
    end
    return TEXEL_W'(packed_texel);
  endfunction

  function automatic void note_fault(string what, logic [TEXEL_W-1:0] want,
                                     logic [TEXEL_W-1:0] got);
    texel_faults++;
    if (texel_faults <= REPORT_LIMIT)
      $display("%0t ns %s: expected %h, got %h", $time, what, want, got);
  endfunction

  // Drive one word at the falling edge and hold it until accepted. The
  // expectation is queued at the accepting edge.
  task automatic send_word(logic [TEXEL_W-1:0] c00, logic [TEXEL_W-1:0] c10,
                           logic [TEXEL_W-1:0] c01, logic [TEXEL_W-1:0] c11,
                           logic [WEIGHT_W-1:0] ws, logic [WEIGHT_W-1:0] wt,
                           logic has_known, logic [TEXEL_W-1:0] known_texel);
    logic [TEXEL_W-1:0] due;
    due = has_known ? known_texel : filter_texel(fmt_now, c00, c10, c01, c11, ws, wt);
    @(negedge clk_i);
    start_i     = 1'b1;
    corner_00_i = c00;
    corner_10_i = c10;
    corner_01_i = c01;
    corner_11_i = c11;
    weight_s_i  = ws;
    weight_t_i  = wt;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    texels_due.push_back(due);
  endtask

  // Weights lean on the interesting spots: 0, exactly 1.0, saturating codes.
  function automatic logic [WEIGHT_W-1:0] random_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WEIGHT_W'(WEIGHT_ONE);
      2:       return WEIGHT_W'($urandom_range(65537, 131071));
      3:       return WEIGHT_W'($urandom_range(0, 131071));
      default: return WEIGHT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [TEXEL_W-1:0] random_corner();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return TEXEL_W'($urandom);
    endcase
  endfunction

  task automatic send_random_word();
    logic [TEXEL_W-1:0]  c00;
    logic [TEXEL_W-1:0]  c10;
    logic [TEXEL_W-1:0]  c01;
    logic [TEXEL_W-1:0]  c11;
    logic [WEIGHT_W-1:0] ws;
    logic [WEIGHT_W-1:0] wt;
    c00 = random_corner();
    c10 = random_corner();
    c01 = random_corner();
    c11 = random_corner();
    ws  = random_weight();
    wt  = random_weight();
    send_word(c00, c10, c01, c11, ws, wt, 1'b0, '0);
  endtask

  task automatic pause_sender(int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (cycles - 1) @(posedge clk_i);
    end
  endtask

  // Hold off until every owed texel has come back.
  task automatic drain_results();
    @(negedge clk_i);
    start_i = 1'b0;
    while (texels_due.size() != 0) @(posedge clk_i);
  endtask

  // Format changes only with the pipe empty. Write data wanders afterwards
  // to show the register ignores it without the enable.
  task automatic write_format(texel_fmt_e fmt);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = fmt;
    fmt_now     = fmt;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'($urandom_range(0, 1));
  endtask

  // Result side: done_o marks a word for one clock, no back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (texels_due.size() == 0)
        note_fault("texel with none pending", 'x, texel_result_o);
      else if (texel_result_o !== texels_due[0]) begin
        note_fault("texel mismatch", texels_due[0], texel_result_o);
        void'(texels_due.pop_front());
      end else
        void'(texels_due.pop_front());
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    texel_vector_t row;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // register written right after reset, to its reset value
    write_format(FMT_1555);

    // directed table; a format change in the table drains the pipe first
    for (int i = 0; i < NUM_VECTORS; i++) begin
      row = TEXEL_VECTORS[i];
      if (row.fmt != fmt_now) write_format(row.fmt);
      send_word(row.c00, row.c10, row.c01, row.c11, row.ws, row.wt,
                row.has_known, row.known_texel);
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 4));
    end

    // random phases alternate the format; bursts of back-to-back words,
    // gaps of random length, sometimes none, now and then a full drain
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_format(texel_fmt_e'(phase % 2));
      sent = 0;
      while (sent < PHASE_WORDS) begin
        burst = $urandom_range(1, 32);
        for (int j = 0; j < burst && sent < PHASE_WORDS; j++) begin
          send_random_word();
          sent++;
        end
        if ($urandom_range(0, 29) == 0)
          drain_results();
        else if ($urandom_range(0, 3) != 0)
          pause_sender($urandom_range(1, 6));
      end
    end

    drain_results();
    repeat (PIPE_FLUSH) @(posedge clk_i);

    if (texel_faults == 0 && texels_due.size() == 0)
      $display("bilinear_texel_16bit regression: pass");
    else
      $display("bilinear_texel_16bit regression: fail");
    $finish;
  end

  // timeout far beyond the length of any correct run
  initial begin
    #2000000;
    $display("bilinear_texel_16bit regression: fail");
    $finish;
  end

endmodule
